@@ rtl/lpht_pkg.sv @@
// lpht_pkg: shared types and codes of the linear probe hash table unit
// used by lpht_ctrl, lpht_datapath and linear_probe_hash_table_unit; no dependencies

package lpht_pkg;

  // operation code of an input word
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } lpht_op_e;

  // status code of a result word
  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_FOUND    = 2'd2,
    STATUS_MISSING  = 2'd3
  } lpht_status_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } lpht_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;   // write one empty slot during the clearing pass
    logic load;         // capture operation and key, start home slot calculation
    logic hash_step;    // advance the remainder unit by one key bit
    logic probe_start;  // set probe address to the home slot, clear counters
    logic probe_run;    // issue slot reads and evaluate returned slots
    logic finish;       // latch the result, store the key on an insert hit
    logic out_load;     // move the latched result into the output register
  } lpht_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;   // clearing pass is at the last slot
    logic hash_done;    // home slot is ready
    logic probe_done;   // evaluated slot ends the probe sequence
  } lpht_sts_t;

endpackage

@@ rtl/lpht_ctrl.sv @@
// lpht_ctrl: sequencing state machine of the linear probe hash table unit
// depends on lpht_pkg; drives lpht_datapath through lpht_cmd_t / lpht_sts_t

module lpht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lpht_pkg::lpht_sts_t sts_i,
  output lpht_pkg::lpht_cmd_t cmd_o
);

  lpht_pkg::lpht_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lpht_pkg::S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = lpht_pkg::S_IDLE;
        end
      end
      lpht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lpht_pkg::S_HASH;
        end
      end
      lpht_pkg::S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_done) begin
          cmd_o.probe_start = 1'b1;
          state_d           = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        cmd_o.probe_run = 1'b1;
        if (sts_i.probe_done) begin
          cmd_o.finish = 1'b1;
          state_d      = lpht_pkg::S_DONE;
        end
      end
      lpht_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpht_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_finish_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.probe_done)
    else $error("result latched before the probe sequence ended");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lpht_pkg::S_DONE))
    else $error("output valid raised outside the done state");
`endif

endmodule

@@ rtl/lpht_datapath.sv @@
// lpht_datapath: slot memory, home slot remainder unit, probe pipeline, result registers
// depends on lpht_pkg; commanded by lpht_ctrl

module lpht_datapath #(
  parameter int SLOTS    = 128,
  parameter int KEY_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpht_pkg::lpht_cmd_t cmd_i,
  output lpht_pkg::lpht_sts_t sts_o,
  input  logic                operation_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic [1:0]          status_o
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int IDX_W  = $clog2(KEY_BITS);
  localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOTS_X    = SLOTS[SLOT_W:0];
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_ALL    = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0]  IDX_TOP    = IDX_W'(KEY_BITS - 1);

  // slot memory, valid bit on top of the key
  logic [KEY_BITS:0] slot_mem_q [SLOTS];

  lpht_pkg::lpht_op_e op_q;
  logic [KEY_BITS-1:0] key_q;

  // home slot remainder unit
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              hash_busy_q, hash_busy_d;
  logic [SLOT_W:0]   rem_shift;

  // probe pipeline
  logic [SLOT_W-1:0] clr_addr_q;
  logic [SLOT_W-1:0] rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]  issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0]  ev_cnt_q, ev_cnt_d;
  logic              ev_vld_q;
  logic [SLOT_W-1:0] ev_addr_q;
  logic [KEY_BITS:0] rdata_q;
  logic              issue;

  logic              hit_empty, hit_equal, probe_last, probe_done;
  lpht_pkg::lpht_status_e result;
  lpht_pkg::lpht_status_e res_q, status_q;

  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [KEY_BITS:0]   mem_wdata;

  // ---------------- remainder unit ----------------
  assign rem_shift = {rem_q, key_q[idx_q]};

  always_comb begin
    rem_d       = rem_q;
    idx_d       = idx_q;
    hash_busy_d = hash_busy_q;
    if (cmd_i.load) begin
      idx_d = IDX_TOP;
      if (SLOTS_POW2) begin
        rem_d       = SLOT_W'(key_i);
        hash_busy_d = 1'b0;
      end else begin
        rem_d       = '0;
        hash_busy_d = 1'b1;
      end
    end else if (cmd_i.hash_step && hash_busy_q) begin
      if (rem_shift >= SLOTS_X) begin
        rem_d = SLOT_W'(rem_shift - SLOTS_X);
      end else begin
        rem_d = SLOT_W'(rem_shift);
      end
      idx_d = idx_q - 1'b1;
      if (idx_q == '0) begin
        hash_busy_d = 1'b0;
      end
    end
  end

  // ---------------- probe evaluation ----------------
  assign hit_empty  = ev_vld_q && !rdata_q[KEY_BITS];
  assign hit_equal  = ev_vld_q && rdata_q[KEY_BITS] && (rdata_q[KEY_BITS-1:0] == key_q);
  assign probe_last = ev_vld_q && (ev_cnt_q == CNT_LAST);
  assign probe_done = hit_empty || (hit_equal && (op_q == lpht_pkg::OP_SEARCH)) || probe_last;

  always_comb begin
    if (op_q == lpht_pkg::OP_INSERT) begin
      result = hit_empty ? lpht_pkg::STATUS_INSERTED : lpht_pkg::STATUS_FULL;
    end else begin
      result = (hit_equal && !hit_empty) ? lpht_pkg::STATUS_FOUND : lpht_pkg::STATUS_MISSING;
    end
  end

  assign issue = cmd_i.probe_run && !probe_done && (issue_cnt_q != CNT_ALL);

  always_comb begin
    rd_addr_d   = rd_addr_q;
    issue_cnt_d = issue_cnt_q;
    ev_cnt_d    = ev_cnt_q;
    if (cmd_i.probe_start) begin
      rd_addr_d   = rem_q;
      issue_cnt_d = '0;
      ev_cnt_d    = '0;
    end else begin
      if (issue) begin
        rd_addr_d   = (rd_addr_q == SLOT_LAST) ? '0 : rd_addr_q + 1'b1;
        issue_cnt_d = issue_cnt_q + 1'b1;
      end
      if (ev_vld_q && cmd_i.probe_run) begin
        ev_cnt_d = ev_cnt_q + 1'b1;
      end
    end
  end

  // memory write: clearing pass or insert into the empty slot found
  assign mem_we    = cmd_i.clear_step ||
                     (cmd_i.finish && (op_q == lpht_pkg::OP_INSERT) && hit_empty);
  assign mem_waddr = cmd_i.clear_step ? clr_addr_q : ev_addr_q;
  assign mem_wdata = cmd_i.clear_step ? '0 : {1'b1, key_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= slot_mem_q[rd_addr_q];
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      hash_busy_q <= 1'b0;
      idx_q       <= '0;
      rd_addr_q   <= '0;
      issue_cnt_q <= '0;
      ev_cnt_q    <= '0;
      ev_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_addr_q <= (clr_addr_q == SLOT_LAST) ? '0 : clr_addr_q + 1'b1;
      end
      hash_busy_q <= hash_busy_d;
      idx_q       <= idx_d;
      rd_addr_q   <= rd_addr_d;
      issue_cnt_q <= issue_cnt_d;
      ev_cnt_q    <= ev_cnt_d;
      ev_vld_q    <= issue;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.load) begin
      op_q  <= lpht_pkg::lpht_op_e'(operation_i);
      key_q <= key_i;
    end
    if (issue) begin
      ev_addr_q <= rd_addr_q;
    end
    if (cmd_i.finish) begin
      res_q <= result;
    end
    if (cmd_i.out_load) begin
      status_q <= res_q;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == SLOT_LAST);
  assign sts_o.hash_done  = !hash_busy_q;
  assign sts_o.probe_done = probe_done;
  assign status_o         = status_q;

`ifndef SYNTHESIS
  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_addr_q <= SLOT_LAST)
    else $error("probe address beyond the last slot");

  a_home_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe_start |-> (rem_q <= SLOT_LAST))
    else $error("home slot beyond the last slot");

  a_probe_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (ev_cnt_q < CNT_ALL))
    else $error("probe sequence ran past one full wrap");
`endif

endmodule

@@ rtl/linear_probe_hash_table_unit.sv @@
// linear_probe_hash_table_unit: top level of the linear probe hash table
// depends on lpht_pkg, lpht_ctrl and lpht_datapath

// Open-addressing hash table of SLOTS entries with linear probing. Each input
// word is an insert (operation 0) or a search (operation 1) of a key; each gives
// exactly one status word: 0 inserted, 1 table full and insert rejected, 2 found,
// 3 not found. The home slot is key mod SLOTS; probing moves forward one slot at
// a time with wraparound and stops at the first empty slot, at an equal key on a
// search, or after one full wrap. Duplicate keys are stored again; there is no
// delete. After reset the block runs a clearing pass over the slot memory and
// holds in_ready_o low until it is done. Each item then goes through these
// steps in order: the word is taken, the home slot is formed, 1 to SLOTS slots
// are probed on the single read port of the slot memory, whose read data is
// registered, and the status is handed to the output register. When SLOTS is
// not a power of two the home slot comes from a bit-serial remainder unit. A
// new word is taken only once these steps are through, but while the previous
// status still waits in the output register.

module linear_probe_hash_table_unit #(
  parameter int SLOTS    = 128,
  parameter int KEY_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [KEY_BITS-1:0] key_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o
);

  // command and status between sequencer and datapath
  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  // sequencer: clearing pass, handshakes, hash / probe / result steps
  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot memory, remainder unit, probe pipeline, output register
  lpht_datapath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .key_i       (key_i),
    .status_o    (status_o)
  );

endmodule
